@@ hdl/sud_pkg.sv @@
// ----------------------------------------------------------------------------
// sud_pkg
// Shared types and constants for the descending sort with duplicate removal.
// ----------------------------------------------------------------------------
package sud_pkg;

   localparam int ValueWidth = 32;
   localparam int CountWidth = 7;
   localparam int TotalWidth = 16;

   localparam logic [TotalWidth-1:0] TotalMax = {TotalWidth{1'b1}};

   typedef logic signed [ValueWidth-1:0] value_type;
   typedef logic [CountWidth-1:0]        count_type;
   typedef logic [TotalWidth-1:0]        total_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;
      logic shift_out;
   } cmd_type;

endpackage

@@ hdl/sud_cell.sv @@
// ----------------------------------------------------------------------------
// sud_cell
// One slot of the sorted chain: holds a value, compares it with the incoming
// word and takes its neighbour's value on insertion or drain.
// ----------------------------------------------------------------------------
module sud_cell (
   input  logic               clock,
   input  logic               reset,
   input  sud_pkg::cmd_type   cmd,
   input  sud_pkg::value_type new_value,
   input  logic               prev_gt,
   input  sud_pkg::value_type prev_value,
   input  logic               prev_valid,
   input  sud_pkg::value_type next_value,
   input  logic               next_valid,
   output sud_pkg::value_type value,
   output logic               valid,
   output logic               gt,
   output logic               eq
);
   import sud_pkg::*;

   value_type value_ff, value_in;
   logic      valid_ff, valid_in;

   assign value = value_ff;
   assign valid = valid_ff;
   assign gt    = valid_ff && (value_ff > new_value);
   assign eq    = valid_ff && (value_ff == new_value);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.shift_out) begin
         value_in = next_value;
         valid_in = next_valid;
      end else if (cmd.insert && !gt) begin
         // the first slot not above the new word takes it; later slots move up
         if (prev_gt) begin
            value_in = new_value;
            valid_in = 1'b1;
         end else begin
            value_in = prev_value;
            valid_in = prev_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

@@ hdl/sort_unique_descending.sv @@
// ----------------------------------------------------------------------------
// sort_unique_descending
// Collects signed words into a sorted chain of cells, dropping duplicates,
// and drains them largest first when the word marked last arrives.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | value, last
//   rsp     | out       | rsp_valid/ready    | sorted_value, distinct_count,
//           |           |                    | total_count, overflowed, end_of_run
//
// One input word is taken per cycle while collecting; every cell compares
// against it in parallel and the chain shifts to open a slot as it is taken.
// After the last word the chain drains one result per cycle through cell 0
// while rsp_ready is high, and the input stays blocked until the run is drained.
// Reset empties the chain and clears the counters at once.
// rsp_ready low holds the drain; req_ready is low for the whole drain.
// ----------------------------------------------------------------------------
module sort_unique_descending #(
   parameter int MAX_DISTINCT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sud_pkg::value_type req_value,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sud_pkg::value_type rsp_sorted_value,
   output sud_pkg::count_type rsp_distinct_count,
   output sud_pkg::total_type rsp_total_count,
   output logic               rsp_overflowed,
   output logic               rsp_end_of_run
);
   import sud_pkg::*;

   value_type cell_value [MAX_DISTINCT];
   logic [MAX_DISTINCT-1:0] cell_valid;
   logic [MAX_DISTINCT-1:0] cell_gt;
   logic [MAX_DISTINCT-1:0] cell_eq;

   cmd_type   cmd;
   logic      req_fire, rsp_fire, dup, full;
   logic      drain_ff, drain_in;
   logic      ovf_ff, ovf_in;
   count_type occ_ff, occ_in;
   total_type total_ff, total_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign dup      = |cell_eq;
   assign full     = cell_valid[MAX_DISTINCT-1];

   assign cmd = cmd_type'{insert: req_fire && !dup && !full, shift_out: rsp_fire};

   for (genvar i = 0; i < MAX_DISTINCT; i++) begin : g_cell
      logic      p_gt, p_valid, n_valid;
      value_type p_value, n_value;
      if (i == 0) begin : g_head
         assign p_gt    = 1'b1;
         assign p_value = req_value;
         assign p_valid = 1'b1;
      end else begin : g_body
         assign p_gt    = cell_gt[i-1];
         assign p_value = cell_value[i-1];
         assign p_valid = cell_valid[i-1];
      end
      if (i == MAX_DISTINCT-1) begin : g_tail
         assign n_value = cell_value[i];
         assign n_valid = 1'b0;
      end else begin : g_next
         assign n_value = cell_value[i+1];
         assign n_valid = cell_valid[i+1];
      end
      sud_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .new_value  (req_value),
         .prev_gt    (p_gt),
         .prev_value (p_value),
         .prev_valid (p_valid),
         .next_value (n_value),
         .next_valid (n_valid),
         .value      (cell_value[i]),
         .valid      (cell_valid[i]),
         .gt         (cell_gt[i]),
         .eq         (cell_eq[i])
      );
   end

   assign req_ready          = !drain_ff;
   assign rsp_valid          = drain_ff;
   assign rsp_sorted_value   = cell_value[0];
   assign rsp_distinct_count = occ_ff;
   assign rsp_total_count    = total_ff;
   assign rsp_overflowed     = ovf_ff;
   // cell 1 empty means cell 0 holds the smallest value
   assign rsp_end_of_run     = !cell_valid[1];

   always_comb begin
      drain_in = drain_ff;
      ovf_in   = ovf_ff;
      occ_in   = occ_ff;
      total_in = total_ff;
      if (req_fire) begin
         if (total_ff != TotalMax) begin
            total_in = total_ff + 1'b1;
         end
         if (cmd.insert) begin
            occ_in = occ_ff + 1'b1;
         end
         if (!dup && full) begin
            ovf_in = 1'b1;
         end
         if (req_last) begin
            drain_in = 1'b1;
         end
      end
      if (rsp_fire && rsp_end_of_run) begin
         drain_in = 1'b0;
         ovf_in   = 1'b0;
         occ_in   = '0;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff <= 1'b0;
         ovf_ff   <= 1'b0;
         occ_ff   <= '0;
         total_ff <= '0;
      end else begin
         drain_ff <= drain_in;
         ovf_ff   <= ovf_in;
         occ_ff   <= occ_in;
         total_ff <= total_in;
      end
   end

   a_rsp_has_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cell_valid[0])
      else $error("result offered from an empty chain");

   a_last_blocks_input: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_last |=> !req_ready && rsp_valid)
      else $error("drain did not start after the last word");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= count_type'(MAX_DISTINCT))
      else $error("occupancy above capacity");

   a_run_end_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_end_of_run |=> req_ready && !cell_valid[0] && occ_ff == '0)
      else $error("chain not empty after the final result");

endmodule
